FILE: sv/srsq_pkg.sv
// Shared constants and types for the sorted range set queue.
package srsq_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_GET    = 1'b1;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } entry_t;

    typedef struct packed {
        logic [31:0] chunk;
        logic        was_empty;
        logic        overflow;
        logic        nonempty;
    } res_t;

endpackage

FILE: sv/sorted_range_set_queue.sv
// Top level of the sorted range set queue: handshakes and output register.
// One transfer is in work at a time; the input is ready only while the sequencer is idle.
// From the accepting edge to the result in the output register, a get or an insert walks one
// range entry per cycle. The sequencer returns to idle on the edge that loads the output register;
// a held result stalls the input.
// Reset clears the range count and the control state; the range memory is not cleared.
module sorted_range_set_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] first_chunk,
    input  logic [31:0] chunk_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] chunk,
    output logic        was_empty,
    output logic        overflow,
    output logic        nonempty
);

    logic           res_valid;
    logic           res_ready;
    srsq_pkg::res_t res;
    srsq_pkg::res_t res_reg;
    logic           out_valid_reg, out_valid_next;

    srsq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req_op    (op),
        .req_first (first_chunk),
        .req_count (chunk_count),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign chunk     = res_reg.chunk;
    assign was_empty = res_reg.was_empty;
    assign overflow  = res_reg.overflow;
    assign nonempty  = res_reg.nonempty;

endmodule

FILE: sv/srsq_engine.sv
// Sequencer and range memory that carry out one insert or get at a time.
module srsq_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                req_op,
    input  logic [31:0]         req_first,
    input  logic [31:0]         req_count,
    output logic                res_valid,
    input  logic                res_ready,
    output srsq_pkg::res_t      res
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_START  = 10'b0000000010,
        S_SEARCH = 10'b0000000100,
        S_FOUND  = 10'b0000001000,
        S_MERGE  = 10'b0000010000,
        S_FIN    = 10'b0000100000,
        S_MOVE   = 10'b0001000000,
        S_PUT    = 10'b0010000000,
        S_GET    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    localparam logic [srsq_pkg::CNT_W-1:0] CNT_ONE = srsq_pkg::CNT_W'(1);
    localparam logic [srsq_pkg::CNT_W-1:0] CNT_MAX = srsq_pkg::CNT_W'(srsq_pkg::MAX_RANGES);

    srsq_pkg::entry_t range_mem [srsq_pkg::MAX_RANGES];
    srsq_pkg::entry_t rd_data_reg;

    state_t state_reg, state_next;
    logic [srsq_pkg::CNT_W-1:0] total_reg, total_next;
    logic                       pend_reg, pend_next;

    logic                       op_reg, op_next;
    logic [31:0]                s_reg, s_next;
    logic [31:0]                n_reg, n_next;
    logic [31:0]                sn_reg, sn_next;
    logic [31:0]                cure_reg, cure_next;
    logic [31:0]                ms_reg, ms_next;
    logic [31:0]                me_reg, me_next;
    logic [srsq_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [srsq_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [srsq_pkg::CNT_W-1:0] src_reg, src_next;
    logic [srsq_pkg::CNT_W-1:0] dst_reg, dst_next;
    logic [srsq_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [srsq_pkg::CNT_W-1:0] d_reg, d_next;
    logic                       up_reg, up_next;
    logic [31:0]                chunk_reg, chunk_next;
    logic                       empty_reg, empty_next;
    logic                       ovf_reg, ovf_next;

    logic                       rd_en;
    logic [srsq_pkg::IDX_W-1:0] rd_addr;
    logic                       wr_en;
    logic [srsq_pkg::IDX_W-1:0] wr_addr;
    srsq_pkg::entry_t           wr_data;

    logic [srsq_pkg::CNT_W-1:0] idx_inc;
    logic [srsq_pkg::CNT_W-1:0] pos_inc;
    logic [srsq_pkg::CNT_W-1:0] gap;
    logic [31:0]                rd_end;

    assign idx_inc = idx_reg + CNT_ONE;
    assign pos_inc = pos_reg + CNT_ONE;
    assign gap     = idx_reg - pos_inc;
    assign rd_end  = rd_data_reg.start + rd_data_reg.len;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            range_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= range_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        pend_next  = pend_reg;
        op_next    = op_reg;
        s_next     = s_reg;
        n_next     = n_reg;
        sn_next    = sn_reg;
        cure_next  = cure_reg;
        ms_next    = ms_reg;
        me_next    = me_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        up_next    = up_reg;
        chunk_next = chunk_reg;
        empty_next = empty_reg;
        ovf_next   = ovf_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_op;
                    s_next     = req_first;
                    n_next     = req_count;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                chunk_next = '0;
                empty_next = 1'b0;
                ovf_next   = 1'b0;
                sn_next    = s_reg + n_reg;
                if (op_reg == srsq_pkg::OP_GET)
                begin
                    if (total_reg == '0)
                    begin
                        empty_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_GET;
                    end
                end
                else if (n_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (total_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = S_PUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    idx_next   = '0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (s_reg <= rd_end)
                begin
                    cure_next  = rd_end;
                    pos_next   = idx_reg;
                    state_next = S_FOUND;
                end
                else if (idx_inc == total_reg)
                begin
                    pos_next = total_reg;
                    if (total_reg == CNT_MAX)
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[srsq_pkg::IDX_W-1:0];
                    idx_next = idx_inc;
                end
            end
            S_FOUND:
            begin
                if (sn_reg < rd_data_reg.start)
                begin
                    if (total_reg == CNT_MAX)
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        up_next    = 1'b1;
                        src_next   = total_reg - CNT_ONE;
                        dst_next   = total_reg;
                        cnt_next   = total_reg - pos_reg;
                        pend_next  = 1'b0;
                        state_next = S_MOVE;
                    end
                end
                else
                begin
                    ms_next  = (s_reg < rd_data_reg.start) ? s_reg : rd_data_reg.start;
                    me_next  = (sn_reg > cure_reg) ? sn_reg : cure_reg;
                    idx_next = pos_inc;
                    if (pos_inc < total_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_inc[srsq_pkg::IDX_W-1:0];
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MERGE:
            begin
                if (me_reg < rd_data_reg.start)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    if (me_reg < rd_end)
                    begin
                        me_next = rd_end;
                    end
                    idx_next = idx_inc;
                    if (idx_inc < total_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[srsq_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg[srsq_pkg::IDX_W-1:0];
                wr_data.start = ms_reg;
                wr_data.len   = me_reg - ms_reg;
                d_next        = gap;
                src_next      = idx_reg;
                dst_next      = pos_inc;
                cnt_next      = (gap == '0) ? '0 : (total_reg - idx_reg);
                up_next       = 1'b0;
                pend_next     = 1'b0;
                state_next    = S_MOVE;
            end
            S_MOVE:
            begin
                if (pend_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = dst_reg[srsq_pkg::IDX_W-1:0];
                    wr_data  = rd_data_reg;
                    dst_next = up_reg ? (dst_reg - CNT_ONE) : (dst_reg + CNT_ONE);
                end
                if (cnt_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = src_reg[srsq_pkg::IDX_W-1:0];
                    src_next  = up_reg ? (src_reg - CNT_ONE) : (src_reg + CNT_ONE);
                    cnt_next  = cnt_reg - CNT_ONE;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (up_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            total_next = total_reg - d_reg;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_PUT:
            begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg[srsq_pkg::IDX_W-1:0];
                wr_data.start = s_reg;
                wr_data.len   = n_reg;
                total_next    = total_reg + CNT_ONE;
                state_next    = S_DONE;
            end
            S_GET:
            begin
                chunk_next = rd_data_reg.start;
                if (rd_data_reg.len > 32'd1)
                begin
                    wr_en         = 1'b1;
                    wr_data.start = rd_data_reg.start + 32'd1;
                    wr_data.len   = rd_data_reg.len - 32'd1;
                    state_next    = S_DONE;
                end
                else
                begin
                    d_next     = CNT_ONE;
                    src_next   = CNT_ONE;
                    dst_next   = '0;
                    cnt_next   = total_reg - CNT_ONE;
                    up_next    = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_MOVE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        s_reg     <= s_next;
        n_reg     <= n_next;
        sn_reg    <= sn_next;
        cure_reg  <= cure_next;
        ms_reg    <= ms_next;
        me_reg    <= me_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        cnt_reg   <= cnt_next;
        d_reg     <= d_next;
        up_reg    <= up_next;
        chunk_reg <= chunk_next;
        empty_reg <= empty_next;
        ovf_reg   <= ovf_next;
    end

    assign req_ready     = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.chunk     = chunk_reg;
    assign res.was_empty = empty_reg;
    assign res.overflow  = ovf_reg;
    assign res.nonempty  = (total_reg != '0);

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the sorted range set queue: directed cases, random bursts, stalls.
module tb;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 2 * srsq_pkg::MAX_RANGES + 10;
    localparam int REPORT_LIMIT  = 100;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        op          = srsq_pkg::OP_INSERT;
    logic [31:0] first_chunk = '0;
    logic [31:0] chunk_count = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] chunk;
    logic        was_empty;
    logic        overflow;
    logic        nonempty;

    logic [31:0] set_start [srsq_pkg::MAX_RANGES];
    logic [31:0] set_len [srsq_pkg::MAX_RANGES];
    int unsigned set_count = 0;

    srsq_pkg::res_t pending_results [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned drops         = 0;
    int unsigned empty_gets    = 0;
    int unsigned errors        = 0;

    sorted_range_set_queue i_dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .op,
        .first_chunk,
        .chunk_count,
        .out_valid,
        .out_ready,
        .chunk,
        .was_empty,
        .overflow,
        .nonempty
    );

    always #1 clk = ~clk;

    function automatic void drop_range(int unsigned idx);
        for (int unsigned k = idx; k + 1 < set_count; k++)
        begin
            set_start[k] = set_start[k + 1];
            set_len[k]   = set_len[k + 1];
        end
        set_count--;
    endfunction

    // Returns 1 when the range is dropped because it needs a new entry and the set is full.
    function automatic logic add_range(logic [31:0] s, logic [31:0] n);
        int unsigned pos;
        logic [31:0] tail;
        pos = 0;
        if (n == 0)
            return 1'b0;
        while (pos < set_count && !(s <= 32'(set_start[pos] + set_len[pos])))
            pos++;
        if (pos >= set_count || 32'(s + n) < set_start[pos])
        begin
            if (set_count >= srsq_pkg::MAX_RANGES)
                return 1'b1;
            for (int unsigned k = set_count; k > pos; k--)
            begin
                set_start[k] = set_start[k - 1];
                set_len[k]   = set_len[k - 1];
            end
            set_start[pos] = s;
            set_len[pos]   = n;
            set_count++;
            return 1'b0;
        end
        if (s < set_start[pos])
        begin
            set_len[pos]   = set_len[pos] + (set_start[pos] - s);
            set_start[pos] = s;
        end
        if (32'(s + n) > 32'(set_start[pos] + set_len[pos]))
            set_len[pos] = 32'(s + n) - set_start[pos];
        while (pos + 1 < set_count)
        begin
            tail = set_start[pos] + set_len[pos];
            if (tail < set_start[pos + 1])
                break;
            if (tail < 32'(set_start[pos + 1] + set_len[pos + 1]))
                set_len[pos] = set_start[pos + 1] + set_len[pos + 1] - set_start[pos];
            drop_range(pos + 1);
        end
        return 1'b0;
    endfunction

    function automatic srsq_pkg::res_t predict_result(logic o, logic [31:0] s, logic [31:0] n);
        srsq_pkg::res_t r;
        r = '0;
        if (o == srsq_pkg::OP_INSERT)
            r.overflow = add_range(s, n);
        else if (set_count == 0)
            r.was_empty = 1'b1;
        else
        begin
            r.chunk = set_start[0];
            if (set_len[0] > 1)
            begin
                set_start[0] = set_start[0] + 1;
                set_len[0]   = set_len[0] - 1;
            end
            else
                drop_range(0);
        end
        r.nonempty = (set_count > 0);
        return r;
    endfunction

    function automatic longint unsigned stored_chunks();
        longint unsigned sum;
        sum = 0;
        for (int unsigned k = 0; k < set_count; k++)
            sum += set_len[k];
        return sum;
    endfunction

    task automatic send_item(input logic o, input logic [31:0] s, input logic [31:0] n);
        int unsigned gap;
        srsq_pkg::res_t r;
        in_valid    <= 1'b1;
        op          <= o;
        first_chunk <= s;
        chunk_count <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_result(o, s, n);
        pending_results.push_back(r);
        items_sent++;
        if (r.overflow)
            drops++;
        if (r.was_empty)
            empty_gets++;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic test_directed();
        send_item(srsq_pkg::OP_GET, 32'h0, 32'h0);
        send_item(srsq_pkg::OP_INSERT, 32'd5, 32'd0);
        send_item(srsq_pkg::OP_INSERT, 32'd100, 32'd10);
        send_item(srsq_pkg::OP_INSERT, 32'd120, 32'd5);
        send_item(srsq_pkg::OP_INSERT, 32'd90, 32'd5);
        send_item(srsq_pkg::OP_INSERT, 32'd110, 32'd10);
        send_item(srsq_pkg::OP_INSERT, 32'd95, 32'd5);
        send_item(srsq_pkg::OP_INSERT, 32'd0, 32'd1);
        send_item(srsq_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(srsq_pkg::OP_GET, 32'h0, 32'h0);
        for (int i = 0; i < srsq_pkg::MAX_RANGES - 1; i++)
            send_item(srsq_pkg::OP_INSERT, 32'(200 + 2 * i), 32'd1);
        send_item(srsq_pkg::OP_INSERT, 32'd1000, 32'd1);
        send_item(srsq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(srsq_pkg::OP_INSERT, 32'd199, 32'd1);
    endtask

    // Bursts mostly of inserts clustered in a window, so that ranges touch and merge, then a run of gets.
    task automatic test_random(input int unsigned count);
        int unsigned stop;
        int unsigned base;
        int unsigned span;
        int unsigned burst;
        int unsigned pick;
        int unsigned drain;
        longint unsigned held;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            base  = $urandom_range(0, 32'hFFFF_F000);
            span  = $urandom_range(24, 200);
            burst = $urandom_range(2, 24);
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    send_item(srsq_pkg::OP_INSERT, $urandom, 32'd0);
                else if (pick < 12)
                    send_item(srsq_pkg::OP_INSERT, $urandom, $urandom_range(1, 4));
                else if (pick < 20)
                    send_item(srsq_pkg::OP_GET, $urandom, $urandom);
                else
                    send_item(srsq_pkg::OP_INSERT, base + $urandom_range(0, span),
                              $urandom_range(1, 3));
            end
            held = stored_chunks();
            if (held > 150)
                held = 150;
            if ($urandom_range(0, 99) < 30)
                drain = int'(held) + 2;
            else
                drain = $urandom_range(0, int'(held));
            repeat (drain) send_item(srsq_pkg::OP_GET, $urandom, $urandom);
        end
    endtask

    task automatic test_backpressure();
        int unsigned saved;
        int unsigned base;
        saved = send_idle_pct;
        send_idle_pct = 0;
        base = $urandom_range(0, 32'hFFFF_F000);
        hold_req <= hold_req + 1;
        for (int i = 0; i < 12; i++)
            send_item((i % 3 == 2) ? srsq_pkg::OP_GET : srsq_pkg::OP_INSERT,
                      base + 32'(4 * i), 32'd2);
        send_idle_pct = saved;
    endtask

    task automatic test_wrap_extremes();
        int unsigned pick;
        repeat (40)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_item(srsq_pkg::OP_INSERT, $urandom, $urandom);
            else if (pick < 60)
                send_item(srsq_pkg::OP_INSERT, 32'hFFFF_FFFF - $urandom_range(0, 15),
                          $urandom_range(1, 64));
            else
                send_item(srsq_pkg::OP_GET, $urandom, $urandom);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        srsq_pkg::res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (errors < REPORT_LIMIT)
                    $display("%0t: unexpected result chunk %h was_empty %b overflow %b nonempty %b",
                             $time, chunk, was_empty, overflow, nonempty);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (srsq_pkg::res_t'({chunk, was_empty, overflow, nonempty}) !== want)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: expected chunk %h was_empty %b overflow %b nonempty %b, %s",
                                 $time, want.chunk, want.was_empty, want.overflow,
                                 want.nonempty,
                                 $sformatf("actual chunk %h was_empty %b overflow %b nonempty %b",
                                           chunk, was_empty, overflow, nonempty));
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("sorted_range_set_queue: mismatch");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(12, 75);
        test_directed();
        test_random(400);
        set_idling(75, 12);
        test_random(400);
        test_backpressure();
        set_idling(0, 0);
        test_random(400);
        test_wrap_extremes();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d input transfers and %0d results, with %0d dropped inserts",
                 items_sent, results_seen, drops);
        $display("and %0d gets on an empty set, under three idling mixes and a long output stall.",
                 empty_gets);
        if (errors == 0)
            $display("sorted_range_set_queue: match");
        else
            $display("sorted_range_set_queue: mismatch");
        $finish;
    end

endmodule
